// ----- rtl/core/aqbp_pkg.sv -----
// Package for the arctangent quantizer and bit packer.
// Holds widths, reset values and the elaboration-time threshold table functions.
// No dependencies.
`default_nettype none

package aqbp_pkg;

  // Configuration and datapath widths
  localparam int unsigned CFG_W             = 4;
  localparam int unsigned CODE_BITS_RST     = 4;
  localparam int unsigned MAX_CODE_BITS_DEF = 8;
  localparam int unsigned SAMPLE_WIDTH_DEF  = 16;
  localparam int unsigned LEVEL_W           = 8;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned THR_W             = 16;
  localparam int unsigned TABLE_DEPTH       = 255;
  localparam int unsigned PEND_CNT_W        = 3;
  localparam int unsigned FIFO_DEPTH        = 4;

  // Q2.30 constants for the sine series
  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam int unsigned Q30_SHIFT = 30;
  localparam int unsigned HALF_TURN = 128;

  typedef struct packed {
    logic [63:0] quo;
    logic [63:0] rem;
  } div_t;

  // Result entry held in the output queue
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_ent_t;

  // Restoring long division, used only while building constants
  function automatic div_t aqbp_udiv(input logic [63:0] num, input logic [63:0] den);
    div_t res;
    logic [63:0] r;
    res.quo = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        res.quo[i] = 1'b1;
      end
    end
    res.rem = r;
    return res;
  endfunction

  // sin(n*pi/256) in unsigned Q2.30, nine-term Taylor series
  function automatic logic [63:0] aqbp_sine_q30(input int unsigned n);
    logic [63:0]        a;
    logic [63:0]        term;
    logic signed [63:0] sum;
    div_t               d;
    a    = (64'(n) * PI_Q30 + 64'd128) >> 8;
    term = a;
    sum  = signed'(a);
    for (int k = 1; k <= 8; k++) begin
      term = (term * a) >> Q30_SHIFT;
      term = (term * a) >> Q30_SHIFT;
      d    = aqbp_udiv(term, 64'((2 * k) * (2 * k + 1)));
      term = d.quo;
      if ((k & 1) != 0) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    return unsigned'(sum);
  endfunction

  // Threshold for 8-bit level i+1: smallest Q8.8 x with atan(x) >= j*pi/256
  function automatic logic signed [THR_W-1:0] aqbp_thr(input int i);
    int                 j;
    int unsigned        m;
    logic [63:0]        s;
    logic [63:0]        c;
    div_t               d;
    logic signed [63:0] v;
    j = i + 1 - int'(HALF_TURN);
    m = (j < 0) ? int'(-j) : int'(j);
    if (m == 0) begin
      return '0;
    end
    s = aqbp_sine_q30(m);
    c = aqbp_sine_q30(HALF_TURN - m);
    if (c == 64'd0) begin
      c = 64'd1;
    end
    d = aqbp_udiv(s << 8, c);
    if (j > 0) begin
      v = signed'(d.quo) + ((d.rem != 64'd0) ? 64'sd1 : 64'sd0);
    end else begin
      v = -signed'(d.quo);
    end
    if (v > 64'sd32767) begin
      v = 64'sd32767;
    end else if (v < -64'sd32768) begin
      v = -64'sd32768;
    end
    return v[THR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/atan_quantize_bit_packer_top.sv -----
// An accepted item waits in the input register; its bytes then enter a 4-entry output queue.
// One item is taken per cycle unless in_stall_o; one byte leaves per cycle unless out_stall_i.
// A final item that spills past a byte adds one extra byte; the queue absorbs it.
// The quantizer is a row of constant compares plus an 8-step thermometer-to-binary select.
// Reset (async, active low) empties the input stage, packer and queue; code_bits goes to 4.
// Quantizer top level; uses aqbp_pkg for widths, the threshold table and queue types.
`default_nettype none

module atan_quantize_bit_packer_top
  import aqbp_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int unsigned SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_we_i,
  input  wire logic [CFG_W-1:0]               cfg_wdata_i,
  // input channel
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  wire logic                           last_sample_i,
  // output channel
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [BYTE_W-1:0]                   packed_byte_o,
  output logic                                last_byte_o
);

  localparam int unsigned CMP_W   = (SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W;
  localparam int unsigned ACC_W   = (1 << PEND_CNT_W) - 1 + MAX_CODE_BITS;
  localparam int unsigned TOT_W   = $clog2((1 << PEND_CNT_W) + MAX_CODE_BITS);
  localparam int unsigned PTR_W   = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W   = $clog2(FIFO_DEPTH + 1);

  // Configuration register
  logic [CFG_W-1:0] code_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_bits_q <= CFG_W'(CODE_BITS_RST);
    end else if (cfg_we_i) begin
      code_bits_q <= cfg_wdata_i;
    end
  end

  // Effective width, clamped to 1..MAX_CODE_BITS
  logic [CFG_W-1:0] bits_eff;

  always_comb begin
    if (code_bits_q == '0) begin
      bits_eff = CFG_W'(1);
    end else if (code_bits_q > CFG_W'(MAX_CODE_BITS)) begin
      bits_eff = CFG_W'(MAX_CODE_BITS);
    end else begin
      bits_eff = code_bits_q;
    end
  end

  // Input stage register
  logic                           s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_WIDTH-1:0] s1_sample_q;
  logic                           s1_last_q;
  logic                           s1_go;
  logic                           in_acc;
  logic [CNT_W-1:0]               fifo_cnt_q, fifo_cnt_d;

  assign s1_go      = s1_valid_q && (fifo_cnt_q <= CNT_W'(FIFO_DEPTH - 2));
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end else begin
      s1_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= sample_i;
      s1_last_q   <= last_sample_i;
    end
  end

  // Threshold compares: thermometer code, monotone in the table index
  logic signed [CMP_W-1:0] samp_ext;
  logic [TABLE_DEPTH-1:0]  therm;

  assign samp_ext = CMP_W'(s1_sample_q);

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_thr
    localparam logic signed [CMP_W-1:0] Th = CMP_W'(aqbp_thr(g));
    assign therm[g] = (samp_ext >= Th);
  end

  // Thermometer to level, one bit per step from the MSB
  logic [LEVEL_W-1:0] lvl;
  logic [LEVEL_W-1:0] cand;

  always_comb begin
    lvl  = '0;
    cand = '0;
    for (int k = LEVEL_W - 1; k >= 0; k--) begin
      cand = lvl | (LEVEL_W'(1) << k);
      if (therm[cand - LEVEL_W'(1)]) begin
        lvl = cand;
      end
    end
  end

  // Code and packing
  logic [MAX_CODE_BITS-1:0] code;
  logic [PEND_CNT_W-1:0]    pend_cnt_q, pend_cnt_d;
  logic [BYTE_W-1:0]        pend_bits_q, pend_bits_d;
  logic [ACC_W-1:0]         acc, acc2;
  logic [TOT_W-1:0]         total, total2;
  logic                     full;
  out_ent_t                 p0, p1, e0;
  logic                     p0_v, p1_v;

  always_comb begin
    code   = MAX_CODE_BITS'(lvl >> (CFG_W'(LEVEL_W) - bits_eff));
    acc    = ACC_W'(pend_bits_q) | (ACC_W'(code) << pend_cnt_q);
    total  = TOT_W'(pend_cnt_q) + TOT_W'(bits_eff);
    full   = (total >= TOT_W'(BYTE_W));
    acc2   = full ? ACC_W'(acc >> BYTE_W) : acc;
    total2 = full ? (total - TOT_W'(BYTE_W)) : total;

    // full byte, then the zero-padded flush on the final item
    p0_v      = s1_go && full;
    p0.data   = acc[BYTE_W-1:0];
    p0.last   = s1_last_q && (total == TOT_W'(BYTE_W));
    p1_v      = s1_go && s1_last_q && (total2 != '0);
    p1.data   = acc2[BYTE_W-1:0];
    p1.last   = 1'b1;
    e0        = p0_v ? p0 : p1;

    if (s1_last_q) begin
      pend_bits_d = '0;
      pend_cnt_d  = '0;
    end else begin
      pend_bits_d = acc2[BYTE_W-1:0];
      pend_cnt_d  = total2[PEND_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_bits_q <= '0;
      pend_cnt_q  <= '0;
    end else if (s1_go) begin
      pend_bits_q <= pend_bits_d;
      pend_cnt_q  <= pend_cnt_d;
    end
  end

  // Output queue
  out_ent_t         fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [1:0]       n_push;
  logic             pop;

  assign n_push      = 2'(p0_v) + 2'(p1_v);
  assign out_valid_o = (fifo_cnt_q != '0);
  assign pop         = out_valid_o && !out_stall_i;
  assign fifo_cnt_d  = fifo_cnt_q + CNT_W'(n_push) - CNT_W'(pop);

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      fifo_q[wr_ptr_q] <= e0;
    end
    if (n_push == 2'd2) begin
      fifo_q[wr_ptr_q + PTR_W'(1)] <= p1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_q + PTR_W'(n_push);
      rd_ptr_q   <= rd_ptr_q + PTR_W'(pop);
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  assign packed_byte_o = fifo_q[rd_ptr_q].data;
  assign last_byte_o   = fifo_q[rd_ptr_q].last;

  // Checks
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("output queue overflow");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_go && s1_last_q) |=> (pend_cnt_q == '0) && (pend_bits_q == '0))
    else $error("packer not empty after final item");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_go) |=> s1_valid_q && $stable(s1_sample_q) && $stable(s1_last_q))
    else $error("held item lost from input stage");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (fifo_cnt_q >= $past(fifo_cnt_q)))
    else $error("queue drained while stalled");

endmodule

`default_nettype wire
